// ----- design/kpit_pkg.sv -----
// ----------------------------------------------------------------------------
// kpit_pkg
// Shared constants and types for the key press and idle timer block.
// ----------------------------------------------------------------------------
`default_nettype none

package kpit_pkg;

    localparam int TICKS_PER_SECOND    = 100;
    localparam int LONG_PRESS_TICKS    = 100;
    localparam int MIN_SHORT_TICKS     = 10;
    localparam int DISPLAY_OFF_SECONDS = 60;
    localparam int SECONDS_PER_MINUTE  = 60;

    localparam int HOLD_W     = 16;
    localparam int SEC_W      = 16;
    localparam int TICK_W     = $clog2(TICKS_PER_SECOND + 1);
    localparam int DISP_SEC_W = $clog2(DISPLAY_OFF_SECONDS + 1);

    localparam int SLEEP_SEC_W = 13;
    localparam int SHUT_MIN_W  = 7;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 2;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;

    // status flag bit positions
    localparam int ST_SLEEP        = 0;
    localparam int ST_POWER_OFF    = 1;
    localparam int ST_DISP_OFF     = 2;
    localparam int ST_DISP_TIMER   = 3;
    localparam int ST_DISP_HANDLED = 4;
    localparam int ST_W            = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLEEP_EN     = 2'd0,
        CFG_SLEEP_SEC    = 2'd1,
        CFG_SHUTDOWN_EN  = 2'd2,
        CFG_SHUTDOWN_MIN = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        REQ_SAMPLE = 1'b0,
        REQ_TICK   = 1'b1
    } req_kind_t;

    typedef struct packed {
        logic sleep_en;
        logic [SLEEP_SEC_W-1:0] sleep_sec;
        logic shutdown_en;
        logic [SHUT_MIN_W-1:0] shutdown_min;
    } idle_cfg_t;

    typedef struct packed {
        logic enter;
        logic quit;
        logic up_short;
        logic up_long;
        logic down_short;
        logic down_long;
        logic beep;
    } key_res_t;

    typedef struct packed {
        logic beep;
        logic sleep_active;
        logic power_off;
        logic display_off;
        logic wake;
    } idle_res_t;

endpackage

`default_nettype wire

// ----- design/kpit_keys.sv -----
// ----------------------------------------------------------------------------
// kpit_keys
// Key arming and press classification with one shared hold counter.
// ----------------------------------------------------------------------------
`default_nettype none

module kpit_keys
    import kpit_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  wire logic req_type,
    input  wire logic mode_pressed,
    input  wire logic up_pressed,
    input  wire logic down_pressed,
    output key_res_t res
);

    localparam logic [HOLD_W-1:0] LP_TICKS  = HOLD_W'(LONG_PRESS_TICKS);
    localparam logic [HOLD_W-1:0] MIN_TICKS = HOLD_W'(MIN_SHORT_TICKS);
    localparam logic [HOLD_W-1:0] HOLD_MAX  = '1;

    logic              mode_armed_reg, mode_armed_next;
    logic              up_armed_reg, up_armed_next;
    logic              down_armed_reg, down_armed_next;
    logic [HOLD_W-1:0] hold_reg, hold_next;
    logic [1:0]        long_reg, long_next;

    always_comb
    begin
        mode_armed_next = mode_armed_reg;
        up_armed_next   = up_armed_reg;
        down_armed_next = down_armed_reg;
        hold_next       = hold_reg;
        long_next       = long_reg;
        res             = '0;
        if (req_type == REQ_SAMPLE)
        begin
            up_armed_next   = up_pressed;
            down_armed_next = down_pressed;
            if (mode_pressed)
            begin
                mode_armed_next = 1'b1;
            end
        end
        else
        begin
            // mode key
            if (mode_armed_reg)
            begin
                if (mode_pressed)
                begin
                    if (hold_next != HOLD_MAX)
                    begin
                        hold_next = hold_next + 1'b1;
                    end
                    res.quit = (hold_next == LP_TICKS);
                end
                else
                begin
                    if (hold_next <= LP_TICKS && hold_next >= MIN_TICKS)
                    begin
                        res.enter       = 1'b1;
                        res.beep        = 1'b1;
                        mode_armed_next = 1'b0;
                    end
                    else if (hold_next > LP_TICKS)
                    begin
                        mode_armed_next = 1'b0;
                    end
                    hold_next = '0;
                end
            end
            // up key
            if (up_armed_reg)
            begin
                if (up_pressed)
                begin
                    if (hold_next <= LP_TICKS)
                    begin
                        hold_next = hold_next + 1'b1;
                    end
                    else
                    begin
                        hold_next     = '0;
                        long_next[0]  = 1'b1;
                        up_armed_next = 1'b0;
                    end
                end
                else if (hold_next <= LP_TICKS)
                begin
                    hold_next     = '0;
                    res.up_short  = 1'b1;
                    res.beep      = 1'b1;
                    up_armed_next = 1'b0;
                end
            end
            else if (!up_pressed)
            begin
                long_next[0] = 1'b0;
            end
            // down key
            if (down_armed_reg)
            begin
                if (down_pressed)
                begin
                    if (hold_next <= LP_TICKS)
                    begin
                        hold_next = hold_next + 1'b1;
                    end
                    else
                    begin
                        hold_next       = '0;
                        long_next[1]    = 1'b1;
                        down_armed_next = 1'b0;
                    end
                end
                else if (hold_next <= LP_TICKS)
                begin
                    hold_next       = '0;
                    res.down_short  = 1'b1;
                    res.beep        = 1'b1;
                    down_armed_next = 1'b0;
                end
            end
            else if (!down_pressed)
            begin
                long_next[1] = 1'b0;
            end
        end
        res.up_long   = long_next[0];
        res.down_long = long_next[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_armed_reg <= 1'b0;
            up_armed_reg   <= 1'b0;
            down_armed_reg <= 1'b0;
            hold_reg       <= '0;
            long_reg       <= '0;
        end
        else if (en)
        begin
            mode_armed_reg <= mode_armed_next;
            up_armed_reg   <= up_armed_next;
            down_armed_reg <= down_armed_next;
            hold_reg       <= hold_next;
            long_reg       <= long_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/kpit_idle.sv -----
// ----------------------------------------------------------------------------
// kpit_idle
// Idle sensor latch with sleep, power-off and display-off second timers.
// ----------------------------------------------------------------------------
`default_nettype none

module kpit_idle
    import kpit_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      en,
    input  wire logic      req_type,
    input  wire logic      idle_sensed,
    input  wire logic      menu_active,
    input  wire idle_cfg_t cfg,
    output idle_res_t      res
);

    localparam logic [TICK_W-1:0]     TPS       = TICK_W'(TICKS_PER_SECOND);
    localparam logic [DISP_SEC_W-1:0] DISP_SECS = DISP_SEC_W'(DISPLAY_OFF_SECONDS);

    logic                  idle_reg, idle_next;
    logic [TICK_W-1:0]     sl_tick_reg, sl_tick_next;
    logic [SEC_W-1:0]      sl_sec_reg, sl_sec_next;
    logic [TICK_W-1:0]     sd_tick_reg, sd_tick_next;
    logic [SEC_W-1:0]      sd_sec_reg, sd_sec_next;
    logic [TICK_W-1:0]     dp_tick_reg, dp_tick_next;
    logic [DISP_SEC_W-1:0] dp_sec_reg, dp_sec_next;
    logic [ST_W-1:0]       flags_reg, flags_next;
    logic [SEC_W-1:0]      shutdown_secs;

    // minutes times sixty as shifts
    assign shutdown_secs = (SEC_W'(cfg.shutdown_min) << 6) - (SEC_W'(cfg.shutdown_min) << 2);

    always_comb
    begin
        idle_next    = idle_reg;
        sl_tick_next = sl_tick_reg;
        sl_sec_next  = sl_sec_reg;
        sd_tick_next = sd_tick_reg;
        sd_sec_next  = sd_sec_reg;
        dp_tick_next = dp_tick_reg;
        dp_sec_next  = dp_sec_reg;
        flags_next   = flags_reg;
        res          = '0;
        if (req_type == REQ_SAMPLE)
        begin
            idle_next = idle_sensed;
        end
        else
        begin
            if (idle_reg)
            begin
                if (cfg.sleep_en)
                begin
                    sl_tick_next = sl_tick_next + 1'b1;
                    if (sl_tick_next == TPS)
                    begin
                        sl_sec_next  = sl_sec_next + 1'b1;
                        sl_tick_next = '0;
                    end
                    if (sl_sec_next == SEC_W'(cfg.sleep_sec))
                    begin
                        if (!menu_active && !flags_reg[ST_POWER_OFF])
                        begin
                            flags_next[ST_SLEEP] = 1'b1;
                            sl_sec_next          = '0;
                            res.beep             = 1'b1;
                        end
                    end
                end
                if (cfg.shutdown_en)
                begin
                    sd_tick_next = sd_tick_next + 1'b1;
                    if (sd_tick_next == TPS)
                    begin
                        sd_sec_next  = sd_sec_next + 1'b1;
                        sd_tick_next = '0;
                    end
                    if (sd_sec_next == shutdown_secs)
                    begin
                        flags_next[ST_POWER_OFF]  = 1'b1;
                        flags_next[ST_DISP_TIMER] = 1'b1;
                        sd_sec_next               = '0;
                    end
                end
                if (flags_next[ST_DISP_TIMER])
                begin
                    dp_tick_next = dp_tick_next + 1'b1;
                    if (dp_tick_next == TPS)
                    begin
                        dp_sec_next  = dp_sec_next + 1'b1;
                        dp_tick_next = '0;
                    end
                    if (dp_sec_next == DISP_SECS)
                    begin
                        flags_next[ST_DISP_OFF]     = 1'b1;
                        flags_next[ST_DISP_HANDLED] = 1'b1;
                        dp_sec_next                 = '0;
                    end
                end
            end
            else
            begin
                sl_tick_next              = '0;
                sl_sec_next               = '0;
                sd_tick_next              = '0;
                sd_sec_next               = '0;
                flags_next[ST_SLEEP]      = 1'b0;
                flags_next[ST_POWER_OFF]  = 1'b0;
                flags_next[ST_DISP_OFF]   = 1'b0;
                flags_next[ST_DISP_TIMER] = 1'b0;
                if (flags_reg[ST_DISP_HANDLED])
                begin
                    res.wake                    = 1'b1;
                    flags_next[ST_DISP_HANDLED] = 1'b0;
                end
            end
            if (menu_active)
            begin
                flags_next[ST_SLEEP]     = 1'b0;
                flags_next[ST_POWER_OFF] = 1'b0;
            end
        end
        res.sleep_active = flags_next[ST_SLEEP];
        res.power_off    = flags_next[ST_POWER_OFF];
        res.display_off  = flags_next[ST_DISP_OFF];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_reg    <= 1'b0;
            sl_tick_reg <= '0;
            sl_sec_reg  <= '0;
            sd_tick_reg <= '0;
            sd_sec_reg  <= '0;
            dp_tick_reg <= '0;
            dp_sec_reg  <= '0;
            flags_reg   <= '0;
        end
        else if (en)
        begin
            idle_reg    <= idle_next;
            sl_tick_reg <= sl_tick_next;
            sl_sec_reg  <= sl_sec_next;
            sd_tick_reg <= sd_tick_next;
            sd_sec_reg  <= sd_sec_next;
            dp_tick_reg <= dp_tick_next;
            dp_sec_reg  <= dp_sec_next;
            flags_reg   <= flags_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/key_press_and_idle_timer.sv -----
// ----------------------------------------------------------------------------
// key_press_and_idle_timer
// The result of an accepted request is registered into the output register.
// Throughput: one request per cycle while the output register is empty or being taken.
// All key and timer state updates in the cycle a request is accepted.
// Async reset (rst_n low) clears key, timer and valid state; config takes defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module key_press_and_idle_timer
    import kpit_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // mode_pressed, up_pressed, down_pressed, idle_sensed, menu_active
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // req_type
    input  wire logic                  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // enter_pulse, quit_pulse, up_short_pulse, up_long_level, down_short_pulse,
    // down_long_level, beep_start, sleep_active, power_off, display_off,
    // display_wake_pulse
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic                  accept;
    key_res_t              key_res;
    idle_res_t             idle_res;
    idle_cfg_t             cfg_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sleep_en     <= 1'b0;
            cfg_reg.sleep_sec    <= SLEEP_SEC_W'(300);
            cfg_reg.shutdown_en  <= 1'b0;
            cfg_reg.shutdown_min <= SHUT_MIN_W'(10);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_SLEEP_EN:     cfg_reg.sleep_en     <= cfg_data[0];
                CFG_SLEEP_SEC:    cfg_reg.sleep_sec    <= cfg_data[SLEEP_SEC_W-1:0];
                CFG_SHUTDOWN_EN:  cfg_reg.shutdown_en  <= cfg_data[0];
                CFG_SHUTDOWN_MIN: cfg_reg.shutdown_min <= cfg_data[SHUT_MIN_W-1:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    kpit_keys u_keys (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (accept),
        .req_type     (s_axis_tuser),
        .mode_pressed (s_axis_tdata[0]),
        .up_pressed   (s_axis_tdata[1]),
        .down_pressed (s_axis_tdata[2]),
        .res          (key_res)
    );

    kpit_idle u_idle (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (accept),
        .req_type    (s_axis_tuser),
        .idle_sensed (s_axis_tdata[3]),
        .menu_active (s_axis_tdata[4]),
        .cfg         (cfg_reg),
        .res         (idle_res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {5'b0,
                              idle_res.wake,
                              idle_res.display_off,
                              idle_res.power_off,
                              idle_res.sleep_active,
                              key_res.beep | idle_res.beep,
                              key_res.down_long,
                              key_res.down_short,
                              key_res.up_long,
                              key_res.up_short,
                              key_res.quit,
                              key_res.enter};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire
